### rtl/vcs_pkg.sv
package vcs_pkg;

    localparam int DOT_W   = 42;
    localparam int SQ_W    = 41;
    localparam int PROD_W  = 82;
    localparam int ROOT_W  = 42;
    localparam int NORM_W  = 21;
    localparam int SIM_W   = 16;
    localparam int QUOT_W  = 57;

    typedef struct packed {
        logic [DOT_W-1:0] dot;
        logic [SQ_W-1:0]  sumsq_a;
        logic [SQ_W-1:0]  sumsq_b;
        logic             too_long;
    } t_job;

endpackage

### rtl/vcs_front.sv
module vcs_front #(
    parameter int MAX_LEN   = 1024,
    parameter int ELEM_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [15:0]    i_elem_a,
    input  logic signed [15:0]    i_elem_b,
    input  logic                  i_last,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output vcs_pkg::t_job         o_job
);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int ESH   = (ELEM_BITS >= 16) ? 0 : 16 - ELEM_BITS;
    localparam bit ZEXT  = (ELEM_BITS > 16);

    logic signed [15:0]          w_a16;
    logic signed [15:0]          w_b16;
    logic signed [16:0]          w_a;
    logic signed [16:0]          w_b;
    logic signed [33:0]          r_pab;
    logic signed [33:0]          r_paa;
    logic signed [33:0]          r_pbb;
    logic                        r_pv;
    logic                        r_plast;
    logic                        r_pskip;
    logic                        r_povf;
    logic [vcs_pkg::DOT_W-1:0]   r_dot;
    logic [vcs_pkg::SQ_W-1:0]    r_sa;
    logic [vcs_pkg::SQ_W-1:0]    r_sb;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_ovf;
    logic                        r_jv;
    vcs_pkg::t_job               r_job;
    logic                        w_acc;
    logic                        w_full;
    logic [vcs_pkg::DOT_W-1:0]   n_dot;
    logic [vcs_pkg::SQ_W-1:0]    n_sa;
    logic [vcs_pkg::SQ_W-1:0]    n_sb;

    // product stage holds when the job slot is busy and a last is pending
    assign o_ready     = !(r_pv && r_plast && r_jv);
    assign w_acc       = i_valid && o_ready;
    assign w_full      = (r_cnt >= CNT_W'(MAX_LEN));
    // sign-extend the low ELEM_BITS bits; wider settings leave the field unsigned
    assign w_a16       = (i_elem_a <<< ESH) >>> ESH;
    assign w_b16       = (i_elem_b <<< ESH) >>> ESH;
    assign w_a         = ZEXT ? $signed({1'b0, i_elem_a}) : 17'(w_a16);
    assign w_b         = ZEXT ? $signed({1'b0, i_elem_b}) : 17'(w_b16);
    assign o_job_valid = r_jv;
    assign o_job       = r_job;

    always_comb begin
        n_dot = r_dot;
        n_sa  = r_sa;
        n_sb  = r_sb;
        if (!r_pskip) begin
            n_dot = r_dot + vcs_pkg::DOT_W'(r_pab);
            n_sa  = r_sa + vcs_pkg::SQ_W'($unsigned(r_paa));
            n_sb  = r_sb + vcs_pkg::SQ_W'($unsigned(r_pbb));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_jv  <= 1'b0;
            r_dot <= '0;
            r_sa  <= '0;
            r_sb  <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            if (r_jv && i_job_ready) r_jv <= 1'b0;
            if (w_acc) begin
                r_pv    <= 1'b1;
                r_plast <= i_last;
                r_pskip <= w_full;
                r_povf  <= r_ovf || w_full;
                r_pab   <= 34'(w_a) * 34'(w_b);
                r_paa   <= 34'(w_a) * 34'(w_a);
                r_pbb   <= 34'(w_b) * 34'(w_b);
                if (i_last) begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end else if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (o_ready) begin
                r_pv <= 1'b0;
            end
            if (r_pv && o_ready) begin
                if (r_plast) begin
                    r_jv             <= 1'b1;
                    r_job.dot        <= n_dot;
                    r_job.sumsq_a    <= n_sa;
                    r_job.sumsq_b    <= n_sb;
                    r_job.too_long   <= r_povf;
                    r_dot <= '0;
                    r_sa  <= '0;
                    r_sb  <= '0;
                end else begin
                    r_dot <= n_dot;
                    r_sa  <= n_sa;
                    r_sb  <= n_sb;
                end
            end
        end
    end
endmodule

### rtl/vcs_back.sv
module vcs_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_job_valid,
    output logic                              o_job_ready,
    input  vcs_pkg::t_job                     i_job,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [vcs_pkg::SIM_W-1:0]  o_similarity,
    output logic signed [vcs_pkg::DOT_W-1:0]  o_dot,
    output logic [vcs_pkg::NORM_W-1:0]        o_norm_a,
    output logic [vcs_pkg::NORM_W-1:0]        o_norm_b,
    output logic                              o_zero_norm,
    output logic                              o_too_long
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SQRT, S_DIV, S_SAT, S_OUT
    } t_state;

    localparam int PW = vcs_pkg::PROD_W;
    localparam int RW = vcs_pkg::ROOT_W;
    localparam int QW = vcs_pkg::QUOT_W;
    localparam int NW = vcs_pkg::NORM_W;
    localparam int XW = vcs_pkg::SQ_W + 1;
    localparam int MW = vcs_pkg::SQ_W + 21;

    t_state              r_state;
    vcs_pkg::t_job       r_job;
    logic                r_mstep;
    logic [PW-1:0]       r_prod;
    logic [RW+1:0]       r_rem;
    logic [RW-1:0]       r_root;
    logic [XW-1:0]       r_xa;
    logic [XW-1:0]       r_xb;
    logic [NW+1:0]       r_rema;
    logic [NW+1:0]       r_remb;
    logic [NW-1:0]       r_ra;
    logic [NW-1:0]       r_rb;
    logic [5:0]          r_it;
    logic [QW-1:0]       r_num;
    logic [RW-1:0]       r_drem;
    logic [QW-1:0]       r_quot;
    logic                r_neg;
    logic                r_zero;
    logic [vcs_pkg::DOT_W-1:0]  w_mag;
    logic [20:0]         w_bsel;
    logic [MW-1:0]       w_pp;
    logic [RW+3:0]       w_rem2;
    logic [RW+3:0]       w_sub;
    logic [NW+3:0]       w_ra2;
    logic [NW+3:0]       w_rb2;
    logic [NW+3:0]       w_suba;
    logic [NW+3:0]       w_subb;
    logic [RW:0]         w_dsh;

    assign w_mag = r_job.dot[vcs_pkg::DOT_W-1] ? (~r_job.dot + 1'b1) : r_job.dot;
    // one 41x21 partial product per step
    assign w_bsel = r_mstep ? r_job.sumsq_b[40:20] : {1'b0, r_job.sumsq_b[19:0]};
    assign w_pp   = r_job.sumsq_a * w_bsel;
    // restoring roots, two bits of radicand per step
    assign w_rem2 = {r_rem, r_prod[PW-1:PW-2]};
    assign w_sub  = {2'b00, r_root, 2'b01};
    assign w_ra2  = {r_rema, r_xa[XW-1:XW-2]};
    assign w_rb2  = {r_remb, r_xb[XW-1:XW-2]};
    assign w_suba = {2'b00, r_ra, 2'b01};
    assign w_subb = {2'b00, r_rb, 2'b01};
    assign w_dsh  = {r_drem, r_num[QW-1]};

    assign o_job_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_mstep <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (!r_mstep) begin
                        r_prod  <= {20'd0, w_pp};
                        r_mstep <= 1'b1;
                    end else begin
                        r_prod  <= r_prod + {w_pp, 20'd0};
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_xa    <= {1'b0, r_job.sumsq_a};
                        r_xb    <= {1'b0, r_job.sumsq_b};
                        r_rema  <= '0;
                        r_remb  <= '0;
                        r_ra    <= '0;
                        r_rb    <= '0;
                        r_it    <= 6'd40;
                        r_zero  <= (r_job.sumsq_a == '0) || (r_job.sumsq_b == '0);
                        r_neg   <= r_job.dot[vcs_pkg::DOT_W-1];
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_prod <= {r_prod[PW-3:0], 2'b00};
                    if (w_rem2 >= w_sub) begin
                        r_rem  <= (RW+2)'(w_rem2 - w_sub);
                        r_root <= {r_root[RW-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem2[RW+1:0];
                        r_root <= {r_root[RW-2:0], 1'b0};
                    end
                    // norm roots take the last 21 steps
                    if (r_it < 6'd21) begin
                        r_xa <= {r_xa[XW-3:0], 2'b00};
                        r_xb <= {r_xb[XW-3:0], 2'b00};
                        if (w_ra2 >= w_suba) begin
                            r_rema <= (NW+2)'(w_ra2 - w_suba);
                            r_ra   <= {r_ra[NW-2:0], 1'b1};
                        end else begin
                            r_rema <= w_ra2[NW+1:0];
                            r_ra   <= {r_ra[NW-2:0], 1'b0};
                        end
                        if (w_rb2 >= w_subb) begin
                            r_remb <= (NW+2)'(w_rb2 - w_subb);
                            r_rb   <= {r_rb[NW-2:0], 1'b1};
                        end else begin
                            r_remb <= w_rb2[NW+1:0];
                            r_rb   <= {r_rb[NW-2:0], 1'b0};
                        end
                    end
                    if (r_it == '0) begin
                        r_num   <= {w_mag, 15'd0};
                        r_drem  <= '0;
                        r_quot  <= '0;
                        r_it    <= 6'd56;
                        r_state <= S_DIV;
                    end else begin
                        r_it <= r_it - 1'b1;
                    end
                end
                S_DIV: begin
                    r_num <= {r_num[QW-2:0], 1'b0};
                    if (w_dsh >= {1'b0, r_root}) begin
                        r_drem <= RW'(w_dsh - {1'b0, r_root});
                        r_quot <= {r_quot[QW-2:0], 1'b1};
                    end else begin
                        r_drem <= w_dsh[RW-1:0];
                        r_quot <= {r_quot[QW-2:0], 1'b0};
                    end
                    if (r_it == '0) r_state <= S_SAT;
                    else            r_it <= r_it - 1'b1;
                end
                S_SAT: begin
                    o_dot       <= r_job.dot;
                    o_norm_a    <= r_ra;
                    o_norm_b    <= r_rb;
                    o_zero_norm <= r_zero;
                    o_too_long  <= r_job.too_long;
                    if (r_zero)
                        o_similarity <= '0;
                    else if (r_neg)
                        o_similarity <= (r_quot > QW'(32768)) ? -16'sd32768
                                      : -$signed(16'(r_quot));
                    else
                        o_similarity <= (r_quot > QW'(32767)) ? 16'sd32767
                                      : $signed(16'(r_quot));
                    o_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/vector_cosine_similarity.sv
// vector_cosine_similarity
// input channel: i_valid/o_ready with i_elem_a, i_elem_b (signed q1.15) and
// i_last marking the final pair of the two vectors; one pair per cycle is
// taken while the accumulators run, unless a last pair waits on a full job register.
// output channel: o_valid/i_ready; one transaction per vector pair, with the
// dot product, both norms, the q1.15 similarity and the zero_norm and
// too_long flags.
// o_valid rises once the last pair has passed the product register and the
// job register, the back has loaded the job and run the split 41x21 multiply
// over two partial products, the two-bit-per-step root of the 82-bit norm
// product (the norm roots run alongside), the bit-serial divider and the
// saturation state; the back takes a new job once its result is accepted.
// the front accumulates the next vector while the back computes; a single
// job register sits between them, so a second last pair waits until the
// back has taken the previous job.
// when the receiver stalls, the result holds on the outputs and the back
// takes no new job.
// reset (synchronous, active low) clears the sums, the element counter and all valids.
module vector_cosine_similarity #(
    parameter int MAX_LEN   = 1024,
    parameter int ELEM_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [15:0]                i_elem_a,
    input  logic signed [15:0]                i_elem_b,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [15:0]                o_similarity,
    output logic signed [41:0]                o_dot,
    output logic [20:0]                       o_norm_a,
    output logic [20:0]                       o_norm_b,
    output logic                              o_zero_norm,
    output logic                              o_too_long
);
    logic          w_jv;
    logic          w_jr;
    vcs_pkg::t_job w_job;

    vcs_front #(.MAX_LEN(MAX_LEN), .ELEM_BITS(ELEM_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_elem_a, .i_elem_b, .i_last,
        .o_job_valid(w_jv), .i_job_ready(w_jr), .o_job(w_job)
    );

    vcs_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_jv), .o_job_ready(w_jr), .i_job(w_job),
        .o_valid, .i_ready, .o_similarity, .o_dot, .o_norm_a, .o_norm_b,
        .o_zero_norm, .o_too_long
    );

`ifndef NO_ASSERTIONS
    a_zero_sim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_norm |-> o_similarity == 16'sd0)
        else $error("similarity nonzero with zero norm");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_dot))
        else $error("result changed under stall");
    a_norm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_norm_a == 21'd0 || o_norm_b == 21'd0) |-> o_zero_norm)
        else $error("zero norm flag missing");
`endif
endmodule
